// ----- rtl/assert_macros.svh -----
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is held
`define TAMC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("tamc assertion failed");
// clocked check that also holds during reset
`define TAMC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("tamc assertion failed");
`else
`define TAMC_ASSERT(lbl, clk_s, rstn_s, prop)
`define TAMC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ----- rtl/tamc_pkg.sv -----
// shared widths, constants and types of the trs affine matrix composer
`timescale 1ns / 1ps
`default_nettype none
package tamc_pkg;
  localparam int POS_W     = 32;
  localparam int QUAT_W    = 16;
  localparam int SCALE_W   = 32;
  localparam int PROD_W    = 2 * QUAT_W;
  localparam int ELEM_W    = PROD_W + 2;
  localparam int MUL_W     = ELEM_W + SCALE_W;
  localparam int FRAC_DROP = 27;
  localparam int OUT_W     = 32;
  localparam int NUM_LANES = 9;

  // one half in units of 2^-28, i.e. 1.0 of the rotation element in units of 2^-27
  localparam logic signed [ELEM_W-1:0] HALF_ELEM = ELEM_W'(64'sd134217728);

  // stage loads shared by all lanes, driven by the top-level flow control
  typedef struct packed {
    logic mul_en;
    logic out_en;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/tamc_scale_lane.sv -----
// one matrix element lane: element times scale, round to Q16.16, saturate
`timescale 1ns / 1ps
`default_nettype none
module tamc_scale_lane (
  input  logic                                    clk,
  input  tamc_pkg::lane_ctl_t                     ctl,
  input  logic signed [tamc_pkg::ELEM_W-1:0]      elem,
  input  logic signed [tamc_pkg::SCALE_W-1:0]     scale,
  output logic signed [tamc_pkg::OUT_W-1:0]       result
);
  localparam int Q_W = tamc_pkg::MUL_W - tamc_pkg::FRAC_DROP;
  localparam logic signed [tamc_pkg::MUL_W-1:0] ROUND_BIAS =
    tamc_pkg::MUL_W'(1) << (tamc_pkg::FRAC_DROP - 1);

  logic signed [tamc_pkg::MUL_W-1:0] mul_r;
  logic signed [tamc_pkg::MUL_W-1:0] mul_nxt;
  logic signed [tamc_pkg::MUL_W-1:0] rnd;
  logic signed [Q_W-1:0]             quo;
  logic signed [tamc_pkg::OUT_W-1:0] res_r;
  logic signed [tamc_pkg::OUT_W-1:0] res_nxt;

  // exact product, units of 2^-43
  assign mul_nxt = tamc_pkg::MUL_W'(elem) * tamc_pkg::MUL_W'(scale);

  // round half up by biasing, then drop fraction bits
  always_comb begin
    rnd = mul_r + ROUND_BIAS;
    quo = rnd[tamc_pkg::MUL_W-1:tamc_pkg::FRAC_DROP];
    // in range when the sign bit of the result and all bits above it agree
    if (&quo[Q_W-1:tamc_pkg::OUT_W-1] || ~|quo[Q_W-1:tamc_pkg::OUT_W-1]) begin
      res_nxt = quo[tamc_pkg::OUT_W-1:0];
    end else if (quo[Q_W-1]) begin
      res_nxt = {1'b1, {(tamc_pkg::OUT_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(tamc_pkg::OUT_W-1){1'b1}}};
    end
  end

  // payload registers, loaded under flow control
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_r <= mul_nxt;
    end
    if (ctl.out_en) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;
endmodule
`default_nettype wire

// ----- rtl/trs_affine_matrix_compose.sv -----
// top level: position, quaternion and scale to the upper three affine rows
//
// Usage: one item on the in_ channel (position, unit quaternion, scale) gives
// one item on the out_ channel with the twelve Q16.16 elements of T*R*S.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low at a rising edge.
// Pipeline: four register stages (quaternion products, rotation elements,
// scale multiply, round and saturate); an item passes through them in that
// order and out_valid is the valid bit of the last stage.
// Throughput: one item per cycle while out_stall is low; each of the nine
// lanes has its own multiplier, so nothing is shared between items in flight.
// Stall: each stage loads when it is empty or its successor moves, so bubbles
// collapse and up to four items sit in the pipe while out_stall is high;
// in_stall rises only when every stage holds an item. The stalled output
// item holds its value.
// Reset: synchronous, rst_n low empties all stages; no items are lost after.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module trs_affine_matrix_compose (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tamc_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [tamc_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [tamc_pkg::POS_W-1:0]     in_pos_z,
  input  logic signed [tamc_pkg::QUAT_W-1:0]    in_quat_x,
  input  logic signed [tamc_pkg::QUAT_W-1:0]    in_quat_y,
  input  logic signed [tamc_pkg::QUAT_W-1:0]    in_quat_z,
  input  logic signed [tamc_pkg::QUAT_W-1:0]    in_quat_w,
  input  logic signed [tamc_pkg::SCALE_W-1:0]   in_scale_x,
  input  logic signed [tamc_pkg::SCALE_W-1:0]   in_scale_y,
  input  logic signed [tamc_pkg::SCALE_W-1:0]   in_scale_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r0_c0,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r0_c1,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r0_c2,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r0_c3,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r1_c0,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r1_c1,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r1_c2,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r1_c3,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r2_c0,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r2_c1,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r2_c2,
  output logic signed [tamc_pkg::OUT_W-1:0]     out_m_r2_c3
);
  localparam int PW = tamc_pkg::PROD_W;
  localparam int EW = tamc_pkg::ELEM_W;
  localparam int SW = tamc_pkg::SCALE_W;
  localparam int XW = tamc_pkg::POS_W;

  // stage valid bits and loads
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: quaternion products, scale and position
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [SW-1:0] s1_scl_r [3];
  logic signed [XW-1:0] s1_pos_r [3];

  // stage 2: rotation elements in units of 2^-27
  logic signed [EW-1:0] elem_r  [tamc_pkg::NUM_LANES];
  logic signed [EW-1:0] elem_nxt [tamc_pkg::NUM_LANES];
  logic signed [SW-1:0] s2_scl_r [3];
  logic signed [XW-1:0] s2_pos_r [3];

  // stages 3 and 4: position travels beside the lanes
  logic signed [XW-1:0] s3_pos_r [3];
  logic signed [XW-1:0] s4_pos_r [3];

  logic signed [tamc_pkg::OUT_W-1:0] lane_res [tamc_pkg::NUM_LANES];
  tamc_pkg::lane_ctl_t               lane_ctl;

  // flow control: a stage loads when empty or when its successor moves
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign lane_ctl = '{mul_en: en3, out_en: en4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // quaternion products, exact in Q4.28
  always_ff @(posedge clk) begin
    if (en1) begin
      xx_r        <= PW'(in_quat_x) * PW'(in_quat_x);
      yy_r        <= PW'(in_quat_y) * PW'(in_quat_y);
      zz_r        <= PW'(in_quat_z) * PW'(in_quat_z);
      xy_r        <= PW'(in_quat_x) * PW'(in_quat_y);
      xz_r        <= PW'(in_quat_x) * PW'(in_quat_z);
      yz_r        <= PW'(in_quat_y) * PW'(in_quat_z);
      wx_r        <= PW'(in_quat_w) * PW'(in_quat_x);
      wy_r        <= PW'(in_quat_w) * PW'(in_quat_y);
      wz_r        <= PW'(in_quat_w) * PW'(in_quat_z);
      s1_scl_r[0] <= in_scale_x;
      s1_scl_r[1] <= in_scale_y;
      s1_scl_r[2] <= in_scale_z;
      s1_pos_r[0] <= in_pos_x;
      s1_pos_r[1] <= in_pos_y;
      s1_pos_r[2] <= in_pos_z;
    end
  end

  // rotation elements, row major: half of the doubled formula
  always_comb begin
    elem_nxt[0] = tamc_pkg::HALF_ELEM - (EW'(yy_r) + EW'(zz_r));
    elem_nxt[1] = EW'(xy_r) - EW'(wz_r);
    elem_nxt[2] = EW'(xz_r) + EW'(wy_r);
    elem_nxt[3] = EW'(xy_r) + EW'(wz_r);
    elem_nxt[4] = tamc_pkg::HALF_ELEM - (EW'(xx_r) + EW'(zz_r));
    elem_nxt[5] = EW'(yz_r) - EW'(wx_r);
    elem_nxt[6] = EW'(xz_r) - EW'(wy_r);
    elem_nxt[7] = EW'(yz_r) + EW'(wx_r);
    elem_nxt[8] = tamc_pkg::HALF_ELEM - (EW'(xx_r) + EW'(yy_r));
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      elem_r   <= elem_nxt;
      s2_scl_r <= s1_scl_r;
      s2_pos_r <= s1_pos_r;
    end
    if (en3) begin
      s3_pos_r <= s2_pos_r;
    end
    if (en4) begin
      s4_pos_r <= s3_pos_r;
    end
  end

  // nine scale lanes, column j takes scale j
  for (genvar i = 0; i < tamc_pkg::NUM_LANES; i++) begin : g_lane
    tamc_scale_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .elem   (elem_r[i]),
      .scale  (s2_scl_r[i % 3]),
      .result (lane_res[i])
    );
  end

  // output mapping
  assign out_valid   = v4_r;
  assign out_m_r0_c0 = lane_res[0];
  assign out_m_r0_c1 = lane_res[1];
  assign out_m_r0_c2 = lane_res[2];
  assign out_m_r0_c3 = s4_pos_r[0];
  assign out_m_r1_c0 = lane_res[3];
  assign out_m_r1_c1 = lane_res[4];
  assign out_m_r1_c2 = lane_res[5];
  assign out_m_r1_c3 = s4_pos_r[1];
  assign out_m_r2_c0 = lane_res[6];
  assign out_m_r2_c1 = lane_res[7];
  assign out_m_r2_c2 = lane_res[8];
  assign out_m_r2_c3 = s4_pos_r[2];

  // checks on the pipeline control
  `TAMC_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (v1_r && v2_r && v3_r && v4_r))
  `TAMC_ASSERT(a_stage3_moves, clk, rst_n, (v3_r && en4) |=> out_valid)
  `TAMC_ASSERT(a_hold_pos, clk, rst_n, (out_valid && out_stall) |=> $stable(s4_pos_r[0]))
  `TAMC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!v1_r && !v2_r && !v3_r && !out_valid))
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the trs affine matrix composer: directed and random items against a predictor
`timescale 1ns / 1ps

module tb;
  localparam int  CLK_PERIOD = 20;
  localparam int  IDLE_LIMIT = 1000;
  localparam int  DRAIN_WAIT = 12;
  localparam int  MAX_WAIT   = 8;
  localparam int  N_ELEMS    = 12;
  localparam int  POS_W      = tamc_pkg::POS_W;
  localparam int  QUAT_W     = tamc_pkg::QUAT_W;
  localparam int  SCALE_W    = tamc_pkg::SCALE_W;
  localparam int  OUT_W      = tamc_pkg::OUT_W;
  localparam int  FRAC_DROP  = tamc_pkg::FRAC_DROP;
  localparam longint ONE_ROT  = longint'(1) << FRAC_DROP;        // 1.0 in units of 2^-27
  localparam longint HALF_LSB = longint'(1) << (FRAC_DROP - 1);  // rounding offset
  localparam longint SAT_MAX  = 64'sd2147483647;
  localparam longint SAT_MIN  = -64'sd2147483648;
  localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
  localparam logic signed [15:0] Q14_ONE = 16'sh4000;
  localparam logic signed [15:0] Q14_COS45 = 16'sd11585;

  // one input item
  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
  } trs_item_t;

  // upper three matrix rows, element r*4+c
  typedef logic [N_ELEMS-1:0][OUT_W-1:0] affine_rows_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [POS_W-1:0]   in_pos_x, in_pos_y, in_pos_z;
  logic signed [QUAT_W-1:0]  in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic signed [SCALE_W-1:0] in_scale_x, in_scale_y, in_scale_z;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] out_m_r0_c0, out_m_r0_c1, out_m_r0_c2, out_m_r0_c3;
  logic signed [OUT_W-1:0] out_m_r1_c0, out_m_r1_c1, out_m_r1_c2, out_m_r1_c3;
  logic signed [OUT_W-1:0] out_m_r2_c0, out_m_r2_c1, out_m_r2_c2, out_m_r2_c3;

  affine_rows_t expected_rows[$];
  affine_rows_t got_rows;
  affine_rows_t want_rows;
  int  error_count;
  int  idle_cycles;
  int  stall_left;
  bit  no_gaps;

  trs_affine_matrix_compose uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_quat_w  (in_quat_w),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_m_r0_c0(out_m_r0_c0),
    .out_m_r0_c1(out_m_r0_c1),
    .out_m_r0_c2(out_m_r0_c2),
    .out_m_r0_c3(out_m_r0_c3),
    .out_m_r1_c0(out_m_r1_c0),
    .out_m_r1_c1(out_m_r1_c1),
    .out_m_r1_c2(out_m_r1_c2),
    .out_m_r1_c3(out_m_r1_c3),
    .out_m_r2_c0(out_m_r2_c0),
    .out_m_r2_c1(out_m_r2_c1),
    .out_m_r2_c2(out_m_r2_c2),
    .out_m_r2_c3(out_m_r2_c3)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // rotation element in units of 2^-27 times a q16.16 scale, rounded half up and saturated
  function automatic logic [OUT_W-1:0] scaled_elem(longint rot, longint scl);
    longint prod;
    longint q;
    prod = rot * scl;
    q = (prod + HALF_LSB) >>> FRAC_DROP;
    if (q > SAT_MAX) q = SAT_MAX;
    if (q < SAT_MIN) q = SAT_MIN;
    return q[OUT_W-1:0];
  endfunction

  // expected matrix rows of translation * rotation * scale
  function automatic affine_rows_t compose_trs(trs_item_t t);
    longint qx, qy, qz, qw, sx, sy, sz;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    affine_rows_t m;
    qx = $signed(t.quat_x);
    qy = $signed(t.quat_y);
    qz = $signed(t.quat_z);
    qw = $signed(t.quat_w);
    sx = $signed(t.scale_x);
    sy = $signed(t.scale_y);
    sz = $signed(t.scale_z);
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    wx = qw * qx; wy = qw * qy; wz = qw * qz;
    m[0]  = scaled_elem(ONE_ROT - (yy + zz), sx);
    m[1]  = scaled_elem(xy - wz, sy);
    m[2]  = scaled_elem(xz + wy, sz);
    m[3]  = t.pos_x;
    m[4]  = scaled_elem(xy + wz, sx);
    m[5]  = scaled_elem(ONE_ROT - (xx + zz), sy);
    m[6]  = scaled_elem(yz - wx, sz);
    m[7]  = t.pos_y;
    m[8]  = scaled_elem(xz - wy, sx);
    m[9]  = scaled_elem(yz + wx, sy);
    m[10] = scaled_elem(ONE_ROT - (xx + yy), sz);
    m[11] = t.pos_z;
    return m;
  endfunction

  // item built from fields
  function automatic trs_item_t make_item(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                          logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                          logic [15:0] qw, logic [31:0] sx, logic [31:0] sy,
                                          logic [31:0] sz);
    trs_item_t t;
    t.pos_x = px; t.pos_y = py; t.pos_z = pz;
    t.quat_x = qx; t.quat_y = qy; t.quat_z = qz; t.quat_w = qw;
    t.scale_x = sx; t.scale_y = sy; t.scale_z = sz;
    return t;
  endfunction

  // boundary values of a q16.16 word
  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5: return Q16_ONE;
      default: return -Q16_ONE;
    endcase
  endfunction

  // scale drawn mostly moderate, sometimes any word or a boundary value
  function automatic logic [31:0] pick_scale();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
    if (kind <= 8) return $urandom;
    return edge_word();
  endfunction

  // random near-unit quaternion with random position and scale
  function automatic trs_item_t unit_item();
    real a, b, c, d, n;
    trs_item_t t;
    a = $urandom_range(0, 65535) - 32768.0;
    b = $urandom_range(0, 65535) - 32768.0;
    c = $urandom_range(0, 65535) - 32768.0;
    d = $urandom_range(0, 65535) - 32768.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 0.0; b = 0.0; c = 0.0; d = 1.0; n = 1.0;
    end
    t.quat_x = $rtoi(a / n * 16384.0);
    t.quat_y = $rtoi(b / n * 16384.0);
    t.quat_z = $rtoi(c / n * 16384.0);
    t.quat_w = $rtoi(d / n * 16384.0);
    t.pos_x = $urandom;
    t.pos_y = $urandom;
    t.pos_z = $urandom;
    t.scale_x = pick_scale();
    t.scale_y = pick_scale();
    t.scale_z = pick_scale();
    return t;
  endfunction

  // drive one item after a random gap (none when no_gaps is set) and wait until it is taken
  task automatic send_item(trs_item_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= t.pos_x;
    in_pos_y   <= t.pos_y;
    in_pos_z   <= t.pos_z;
    in_quat_x  <= t.quat_x;
    in_quat_y  <= t.quat_y;
    in_quat_z  <= t.quat_z;
    in_quat_w  <= t.quat_w;
    in_scale_x <= t.scale_x;
    in_scale_y <= t.scale_y;
    in_scale_z <= t.scale_z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rows.insert(expected_rows.size(), compose_trs(t));
  endtask

  // identity rotation with unit and other scales, position extremes
  task automatic test_identity();
    send_item(make_item(0, 0, 0, 0, 0, 0, Q14_ONE, Q16_ONE, Q16_ONE, Q16_ONE));
    send_item(make_item(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0, Q14_ONE,
                        Q16_ONE, -Q16_ONE, 32'h0002_8000));
    send_item(make_item(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 0, 0, 0, -Q14_ONE,
                        32'h0000_0001, 32'hffff_ffff, 0));
  endtask

  // quarter turns about each axis and a half turn
  task automatic test_axis_turns();
    send_item(make_item(1, 2, 3, Q14_COS45, 0, 0, Q14_COS45, Q16_ONE, Q16_ONE, Q16_ONE));
    send_item(make_item(4, 5, 6, 0, Q14_COS45, 0, Q14_COS45, Q16_ONE, 2 * Q16_ONE, Q16_ONE));
    send_item(make_item(7, 8, 9, 0, 0, Q14_COS45, Q14_COS45, 3 * Q16_ONE, Q16_ONE, -Q16_ONE));
    send_item(make_item(0, 0, 0, 0, 0, Q14_ONE, 0, Q16_ONE, Q16_ONE, Q16_ONE));
  endtask

  // component and scale extremes, zero and oversized quaternions, saturation
  task automatic test_field_extremes();
    send_item(make_item(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_item(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(make_item(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    send_item(make_item(0, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 0, 0, 16'h7fff,
                        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
  endtask

  // products landing exactly on and beside the half lsb
  task automatic test_round_ties();
    send_item(make_item(0, 0, 0, 1, 1, 0, 0, Q16_ONE, 32'h0400_0000, Q16_ONE));
    send_item(make_item(0, 0, 0, 1, 1, 0, 0, Q16_ONE, 32'hfc00_0000, Q16_ONE));
    send_item(make_item(0, 0, 0, 1, 1, 0, 0, Q16_ONE, 32'h03ff_ffff, Q16_ONE));
    send_item(make_item(0, 0, 0, 1, 1, 0, 0, Q16_ONE, 32'hfbff_ffff, Q16_ONE));
  endtask

  // random rotations with random gaps
  task automatic test_random_unit(int count);
    repeat (count) send_item(unit_item());
  endtask

  // every bit of every field random, boundary words mixed in
  task automatic test_random_noise(int count);
    trs_item_t t;
    repeat (count) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) t.scale_x = edge_word();
      if ($urandom_range(0, 3) == 0) t.pos_y = edge_word();
      send_item(t);
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    repeat (count) send_item(unit_item());
    no_gaps = 1'b0;
  endtask

  // compare each taken result with the oldest expectation, then draw the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_rows = {out_m_r2_c3, out_m_r2_c2, out_m_r2_c1, out_m_r2_c0,
                  out_m_r1_c3, out_m_r1_c2, out_m_r1_c1, out_m_r1_c0,
                  out_m_r0_c3, out_m_r0_c2, out_m_r0_c1, out_m_r0_c0};
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected matrix item, expected none actual %h", $time, got_rows);
        error_count = error_count + 1;
      end else begin
        want_rows = expected_rows.pop_front();
        for (int i = 0; i < N_ELEMS; i++) begin
          if (got_rows[i] !== want_rows[i]) begin
            $display("%0t: m_r%0d_c%0d expected %h actual %h", $time, i / 4, i % 4,
                     want_rows[i], got_rows[i]);
            error_count = error_count + 1;
          end
        end
      end
      stall_left <= no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // main sequence
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_pos_z    = '0;
    in_quat_x   = '0;
    in_quat_y   = '0;
    in_quat_z   = '0;
    in_quat_w   = '0;
    in_scale_x  = '0;
    in_scale_y  = '0;
    in_scale_z  = '0;
    error_count = 0;
    idle_cycles = 0;
    stall_left  = 0;
    no_gaps     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_identity();
    test_axis_turns();
    test_field_extremes();
    test_round_ties();
    test_random_unit(1000);
    test_back_to_back(150);
    test_random_noise(400);
    test_back_to_back(180);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
